/* design/ksm_pkg.sv */
// ----------------------------------------------------------------------------
// ksm_pkg
// Shared types, constants and the control program of the scalar Kalman
// smoother: register map, control word layout and the step table.
// ----------------------------------------------------------------------------
package ksm_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned GAIN_W    = 31;
   localparam int unsigned ADDR_W    = 4;
   localparam int unsigned STEP_W    = 4;
   localparam int unsigned CNT_W     = 5;
   localparam int unsigned DIV_ITERS = 31;

   localparam logic [GAIN_W-1:0] ONE_Q30 = 31'd1073741824;

   localparam logic [DATA_W-1:0] PROC_VAR_RESET = 32'd429496730;
   localparam logic [DATA_W-1:0] MEAS_VAR_RESET = 32'd32212255;
   localparam logic [DATA_W-1:0] ERR_INIT_RESET = 32'd1073741824;

   // register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_PROC_VAR = 2'd0;
   localparam logic [1:0] REG_MEAS_VAR = 2'd1;
   localparam logic [1:0] REG_ERR_INIT = 2'd2;

   typedef logic [STEP_W-1:0] step_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   // program steps
   localparam step_type ST_WAIT     = 4'd0;
   localparam step_type ST_MUL_PQ   = 4'd1;
   localparam step_type ST_PREDICT  = 4'd2;
   localparam step_type ST_DIV_INIT = 4'd3;
   localparam step_type ST_DIV_STEP = 4'd4;
   localparam step_type ST_DIFF     = 4'd5;
   localparam step_type ST_MUL_CORR = 4'd6;
   localparam step_type ST_CORRECT  = 4'd7;
   localparam step_type ST_MUL_P    = 4'd8;
   localparam step_type ST_UPDATE_P = 4'd9;
   localparam step_type ST_EMIT     = 4'd10;

   typedef enum logic [1:0] {
      MUL_PQ   = 2'd0,
      MUL_CORR = 2'd1,
      MUL_P    = 2'd2
   } mul_sel_type;

   typedef enum logic [2:0] {
      COND_NEVER    = 3'd0,
      COND_ALWAYS   = 3'd1,
      COND_NO_REQ   = 3'd2,
      COND_CNT_NZ   = 3'd3,
      COND_OUT_BUSY = 3'd4
   } cond_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        wait_req;
      logic        mul_en;
      logic        predict_en;
      logic        div_init;
      logic        div_step;
      logic        diff_en;
      logic        correct_en;
      logic        update_en;
      logic        emit;
      logic        last;
      cond_type    cond;
      step_type    target;
   } ctl_type;

   typedef struct packed {
      logic req_valid;
      logic cnt_nz;
      logic out_busy;
   } stat_type;

   typedef struct packed {
      logic [DATA_W-1:0] proc_var;
      logic [DATA_W-1:0] meas_var;
      logic [DATA_W-1:0] err_init;
   } cfg_type;

   function automatic ctl_type ucode_word(input step_type step);
      ctl_type c;
      c = '{mul_sel: MUL_PQ, wait_req: 1'b0, mul_en: 1'b0, predict_en: 1'b0,
            div_init: 1'b0, div_step: 1'b0, diff_en: 1'b0, correct_en: 1'b0,
            update_en: 1'b0, emit: 1'b0, last: 1'b0, cond: COND_NEVER,
            target: ST_WAIT};
      unique case (step)
         ST_WAIT: begin
            c.wait_req = 1'b1;
            c.cond     = COND_NO_REQ;
            c.target   = ST_WAIT;
         end
         ST_MUL_PQ: begin
            c.mul_en  = 1'b1;
            c.mul_sel = MUL_PQ;
         end
         ST_PREDICT:  c.predict_en = 1'b1;
         ST_DIV_INIT: c.div_init   = 1'b1;
         ST_DIV_STEP: begin
            c.div_step = 1'b1;
            c.cond     = COND_CNT_NZ;
            c.target   = ST_DIV_STEP;
         end
         ST_DIFF: c.diff_en = 1'b1;
         ST_MUL_CORR: begin
            c.mul_en  = 1'b1;
            c.mul_sel = MUL_CORR;
         end
         ST_CORRECT: c.correct_en = 1'b1;
         ST_MUL_P: begin
            c.mul_en  = 1'b1;
            c.mul_sel = MUL_P;
         end
         ST_UPDATE_P: c.update_en = 1'b1;
         ST_EMIT: begin
            c.emit   = 1'b1;
            c.last   = 1'b1;
            c.cond   = COND_OUT_BUSY;
            c.target = ST_EMIT;
         end
         default: begin
            c.cond   = COND_ALWAYS;
            c.target = ST_WAIT;
         end
      endcase
      return c;
   endfunction

endpackage

/* design/ksm_req_if.sv */
// ----------------------------------------------------------------------------
// ksm_req_if
// Sample channel: valid/ready handshake carrying one sample and its
// restart flag.
// ----------------------------------------------------------------------------
interface ksm_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ksm_pkg::DATA_W-1:0]   sample;
   logic                                first;

   modport source (output valid, output sample, output first, input ready);
   modport sink   (input valid, input sample, input first, output ready);
endinterface

/* design/ksm_rsp_if.sv */
// ----------------------------------------------------------------------------
// ksm_rsp_if
// Result channel: valid/ready handshake carrying the filtered estimate and
// the gain used for that sample.
// ----------------------------------------------------------------------------
interface ksm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ksm_pkg::DATA_W-1:0]   estimate;
   logic        [ksm_pkg::GAIN_W-1:0]   gain;

   modport source (output valid, output estimate, output gain, input ready);
   modport sink   (input valid, input estimate, input gain, output ready);
endinterface

/* design/scalar_kalman_smoother_core.sv */
// ----------------------------------------------------------------------------
// scalar_kalman_smoother_core
// One-dimensional Kalman-style smoother: predict, gain by serial division,
// correct and error update, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// A new sample is taken only when the sequencer is back at its wait step;
// the 31-step gain division loop on the divider's own subtractor takes
// most of the program.
// A result waiting on rsp holds the sequencer only at its final step.
// Reset (synchronous): estimate and error covariance clear to zero, the
// registers take their defaults, no result is pending.
module scalar_kalman_smoother_core (
   input  logic                          clock,
   input  logic                          reset,
   ksm_req_if.sink                       req,
   ksm_rsp_if.source                     rsp,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ksm_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [ksm_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [ksm_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);

   ksm_pkg::cfg_type  cfg;
   ksm_pkg::ctl_type  ctl;
   ksm_pkg::stat_type stat;

   ksm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ksm_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   ksm_datapath u_dp (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .cfg   (cfg),
      .stat  (stat),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

/* design/ksm_csr.sv */
// ----------------------------------------------------------------------------
// ksm_csr
// APB-style register block holding process noise, measurement noise and
// the initial error covariance.
// ----------------------------------------------------------------------------
module ksm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ksm_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [ksm_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [ksm_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready,
   output ksm_pkg::cfg_type              cfg
);

   ksm_pkg::cfg_type cfg_ff;
   ksm_pkg::cfg_type cfg_in;
   logic [1:0]       index;
   logic             wr_en;

   assign index      = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            ksm_pkg::REG_PROC_VAR: cfg_in.proc_var = csr_pwdata;
            ksm_pkg::REG_MEAS_VAR: cfg_in.meas_var = csr_pwdata;
            ksm_pkg::REG_ERR_INIT: cfg_in.err_init = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         ksm_pkg::REG_PROC_VAR: csr_prdata = cfg_ff.proc_var;
         ksm_pkg::REG_MEAS_VAR: csr_prdata = cfg_ff.meas_var;
         ksm_pkg::REG_ERR_INIT: csr_prdata = cfg_ff.err_init;
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.proc_var <= ksm_pkg::PROC_VAR_RESET;
         cfg_ff.meas_var <= ksm_pkg::MEAS_VAR_RESET;
         cfg_ff.err_init <= ksm_pkg::ERR_INIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/ksm_sequencer.sv */
// ----------------------------------------------------------------------------
// ksm_sequencer
// Step counter over the control program; issues one control word per
// cycle and takes conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module ksm_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  ksm_pkg::stat_type  stat,
   output ksm_pkg::ctl_type   ctl
);

   ksm_pkg::step_type step_ff;
   ksm_pkg::step_type step_in;
   logic              taken;

   assign ctl = ksm_pkg::ucode_word(step_ff);

   always_comb begin
      unique case (ctl.cond)
         ksm_pkg::COND_NEVER:    taken = 1'b0;
         ksm_pkg::COND_ALWAYS:   taken = 1'b1;
         ksm_pkg::COND_NO_REQ:   taken = !stat.req_valid;
         ksm_pkg::COND_CNT_NZ:   taken = stat.cnt_nz;
         ksm_pkg::COND_OUT_BUSY: taken = stat.out_busy;
         default:                taken = 1'b1;
      endcase
   end

   always_comb begin
      priority if (taken) begin
         step_in = ctl.target;
      end else if (ctl.last) begin
         step_in = ksm_pkg::ST_WAIT;
      end else begin
         step_in = step_ff + ksm_pkg::step_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ksm_pkg::ST_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

/* design/ksm_datapath.sv */
// ----------------------------------------------------------------------------
// ksm_datapath
// Filter state, one shared 33x32 multiplier, a radix-2 restoring divider
// for the gain, saturating adders and the result register.
// ----------------------------------------------------------------------------
module ksm_datapath (
   input  logic              clock,
   input  logic              reset,
   input  ksm_pkg::ctl_type  ctl,
   input  ksm_pkg::cfg_type  cfg,
   output ksm_pkg::stat_type stat,
   ksm_req_if.sink           req,
   ksm_rsp_if.source         rsp
);

   logic signed [31:0] est_ff,    est_in;
   logic        [31:0] p_ff,      p_in;
   logic signed [31:0] sample_ff, sample_in;
   logic        [64:0] prod_ff,   prod_in;
   logic        [32:0] den_ff,    den_in;
   logic        [33:0] rem_ff,    rem_in;
   logic               nbit_ff,   nbit_in;
   ksm_pkg::cnt_type   cnt_ff,    cnt_in;
   logic        [30:0] q_ff,      q_in;
   logic        [30:0] k_ff,      k_in;
   logic        [32:0] mag_ff,    mag_in;
   logic               neg_ff,    neg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_est_ff,   rsp_est_in;
   logic        [30:0] rsp_gain_ff,  rsp_gain_in;

   logic        [32:0] mul_a;
   logic        [31:0] mul_b;
   logic               req_fire;
   logic               out_busy;
   logic signed [33:0] pred_sum;
   logic        [35:0] p_sum;
   logic        [33:0] div_sh;
   logic        [34:0] div_diff;
   logic signed [32:0] diff;
   logic        [63:0] rnd_sum;
   logic        [33:0] corr;
   logic signed [35:0] corr_sum;

   function automatic logic signed [31:0] sat_s34(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -34'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat_s36(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -36'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   assign req.ready = ctl.wait_req;
   assign req_fire  = req.valid && ctl.wait_req;
   assign out_busy  = rsp_valid_ff && !rsp.ready;

   assign stat.req_valid = req.valid;
   assign stat.cnt_nz    = (cnt_ff != '0);
   assign stat.out_busy  = out_busy;

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.estimate = rsp_est_ff;
   assign rsp.gain     = rsp_gain_ff;

   // shared multiplier operands
   always_comb begin
      unique case (ctl.mul_sel)
         ksm_pkg::MUL_PQ: begin
            mul_a = {1'b0, p_ff};
            mul_b = cfg.proc_var;
         end
         ksm_pkg::MUL_CORR: begin
            mul_a = mag_ff;
            mul_b = {1'b0, k_ff};
         end
         ksm_pkg::MUL_P: begin
            mul_a = {1'b0, p_ff};
            mul_b = {1'b0, ksm_pkg::ONE_Q30 - k_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      pred_sum = {{2{est_ff[31]}}, est_ff} + $signed({14'd0, prod_ff[63:44]});
      p_sum    = {4'd0, p_ff} + {1'b0, prod_ff[63:29]};
      div_sh   = {rem_ff[32:0], nbit_ff};
      div_diff = {1'b0, div_sh} - {2'b00, den_ff};
      diff     = {sample_ff[31], sample_ff} - {est_ff[31], est_ff};
      rnd_sum  = prod_ff[63:0] + 64'd536870912;
      corr     = rnd_sum[63:30];
      if (neg_ff) begin
         corr_sum = {{4{est_ff[31]}}, est_ff} - $signed({2'b00, corr});
      end else begin
         corr_sum = {{4{est_ff[31]}}, est_ff} + $signed({2'b00, corr});
      end
   end

   always_comb begin
      est_in       = est_ff;
      p_in         = p_ff;
      sample_in    = sample_ff;
      prod_in      = prod_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      nbit_in      = nbit_ff;
      cnt_in       = cnt_ff;
      q_in         = q_ff;
      k_in         = k_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_est_in   = rsp_est_ff;
      rsp_gain_in  = rsp_gain_ff;

      // restart on a first sample
      if (req_fire) begin
         sample_in = req.sample;
         if (req.first) begin
            est_in = req.sample;
            p_in   = cfg.err_init;
         end
      end

      if (ctl.mul_en) begin
         prod_in = mul_a * mul_b;
      end

      if (ctl.predict_en) begin
         est_in = sat_s34(pred_sum);
         p_in   = (p_sum[35:32] != 4'd0) ? 32'hFFFF_FFFF : p_sum[31:0];
      end

      // P*2^30 / (P+R): quotient fits 31 bits, so start with P >> 1
      if (ctl.div_init) begin
         den_in  = {1'b0, p_ff} + {1'b0, cfg.meas_var};
         rem_in  = {3'd0, p_ff[31:1]};
         nbit_in = p_ff[0];
         cnt_in  = ksm_pkg::cnt_type'(ksm_pkg::DIV_ITERS - 1);
         q_in    = '0;
      end

      if (ctl.div_step) begin
         nbit_in = 1'b0;
         if (!div_diff[34]) begin
            rem_in = div_diff[33:0];
            q_in   = {q_ff[29:0], 1'b1};
         end else begin
            rem_in = div_sh;
            q_in   = {q_ff[29:0], 1'b0};
         end
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - ksm_pkg::cnt_type'(1);
         end
      end

      if (ctl.diff_en) begin
         k_in   = (den_ff == 33'd0) ? 31'd0 : q_ff;
         neg_in = diff[32];
         mag_in = diff[32] ? 33'(-diff) : 33'(diff);
      end

      if (ctl.correct_en) begin
         est_in = sat_s36(corr_sum);
      end

      if (ctl.update_en) begin
         p_in = prod_ff[61:30];
      end

      // drop the result once transferred, load a new one when free
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.emit && !out_busy) begin
         rsp_valid_in = 1'b1;
         rsp_est_in   = est_ff;
         rsp_gain_in  = k_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff       <= '0;
         p_ff         <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         est_ff       <= est_in;
         p_ff         <= p_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      prod_ff     <= prod_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      nbit_ff     <= nbit_in;
      q_ff        <= q_in;
      k_ff        <= k_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_gain_ff <= rsp_gain_in;
   end

endmodule

/* test/scalar_kalman_smoother_core_tb.sv */
// ----------------------------------------------------------------------------
// scalar_kalman_smoother_core_tb
// Self-checking bench for the scalar Kalman smoother. A bit-exact predictor
// tracks estimate, error covariance and the noise registers, and checks each
// result transfer in order. Directed cases cover field extremes, restarts,
// the reset state and a zero gain denominator. Random phases follow, most
// with new noise settings and random idling on the channels; one phase holds
// results off for long, and the last runs calm on the reset defaults.
// ----------------------------------------------------------------------------
module scalar_kalman_smoother_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // index past the register map; writes to it are dropped
   localparam logic [1:0] REG_UNMAPPED = 2'd3;
   localparam int unsigned DRAIN_CYCLES = 50;
   localparam int unsigned PHASE_ITEMS  = 118;
   localparam int unsigned PHASES       = 8;

   typedef struct {
      logic signed [ksm_pkg::DATA_W-1:0] estimate;
      logic        [ksm_pkg::GAIN_W-1:0] gain;
   } kalman_out_type;

   class kalman_scoreboard;
      logic        [ksm_pkg::DATA_W-1:0] q_noise;
      logic        [ksm_pkg::DATA_W-1:0] r_noise;
      logic        [ksm_pkg::DATA_W-1:0] p_init;
      logic signed [ksm_pkg::DATA_W-1:0] est;
      logic        [ksm_pkg::DATA_W-1:0] p_cov;
      kalman_out_type                    pending[$];
      int                                errors;

      function new();
         q_noise = ksm_pkg::PROC_VAR_RESET;
         r_noise = ksm_pkg::MEAS_VAR_RESET;
         p_init  = ksm_pkg::ERR_INIT_RESET;
         est     = '0;
         p_cov   = '0;
         errors  = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [ksm_pkg::DATA_W-1:0] val);
         case (idx)
            ksm_pkg::REG_PROC_VAR: q_noise = val;
            ksm_pkg::REG_MEAS_VAR: r_noise = val;
            ksm_pkg::REG_ERR_INIT: p_init  = val;
            default: ;
         endcase
      endfunction

      function logic signed [ksm_pkg::DATA_W-1:0] clamp32(longint v);
         if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
         if (v < -longint'(64'h8000_0000)) return 32'sh8000_0000;
         return v[ksm_pkg::DATA_W-1:0];
      endfunction

      function void note_sample(logic signed [ksm_pkg::DATA_W-1:0] s, logic f);
         bit [63:0]      pq, p64, den, k, mag, corr, one, prod;
         longint         diff;
         kalman_out_type x;
         one = 64'(ksm_pkg::ONE_Q30);
         if (f) begin
            est   = s;
            p_cov = p_init;
         end
         // predict, kept in its non-textbook form
         pq  = {32'b0, p_cov} * {32'b0, q_noise};
         est = clamp32(longint'(est) + longint'(pq >> 44));
         p64 = {32'b0, p_cov} + (pq >> 29);
         if (p64 > 64'h0000_0000_FFFF_FFFF) p64 = 64'h0000_0000_FFFF_FFFF;
         p_cov = p64[31:0];
         // gain
         den = {32'b0, p_cov} + {32'b0, r_noise};
         if (den == 0) k = 0;
         else k = ({32'b0, p_cov} << 30) / den;
         if (k > one) k = one;
         // correct, rounding ties away from zero
         diff = longint'(s) - longint'(est);
         mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
         corr = (mag * k + (64'd1 << 29)) >> 30;
         if (diff < 0) est = clamp32(longint'(est) - longint'(corr));
         else est = clamp32(longint'(est) + longint'(corr));
         prod  = ((one - k) * {32'b0, p_cov}) >> 30;
         p_cov = prod[31:0];
         x.estimate = est;
         x.gain     = k[ksm_pkg::GAIN_W-1:0];
         pending.push_back(x);
      endfunction

      function void check_result(logic signed [ksm_pkg::DATA_W-1:0] e,
                                 logic [ksm_pkg::GAIN_W-1:0] g);
         kalman_out_type x;
         if (pending.size() == 0) begin
            $error("unexpected result: estimate %0d gain %0d", e, g);
            errors++;
            return;
         end
         x = pending.pop_front();
         if (e !== x.estimate) begin
            $error("estimate: expected %0d actual %0d", x.estimate, e);
            errors++;
         end
         if (g !== x.gain) begin
            $error("gain: expected %0d actual %0d", x.gain, g);
            errors++;
         end
      endfunction

      function bit drained();
         return pending.size() == 0;
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [ksm_pkg::ADDR_W-1:0] csr_paddr;
   logic [ksm_pkg::DATA_W-1:0] csr_pwdata;
   logic [ksm_pkg::DATA_W-1:0] csr_prdata;
   logic                       csr_pready;

   ksm_req_if req_ch();
   ksm_rsp_if rsp_ch();

   scalar_kalman_smoother_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   kalman_scoreboard sb = new();

   bit          calm;
   bit          tx_idle_on;
   bit          rx_idle_on;
   int unsigned hold_len;
   int          level;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("FAILURE");
      $finish;
   end

   // result side: random stalls, one long hold on request
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.estimate, rsp_ch.gain);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_len > 0) begin
            stall_left = hold_len - 1;
            hold_len   = 0;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && rx_idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [ksm_pkg::DATA_W-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic send_sample(logic signed [ksm_pkg::DATA_W-1:0] s, logic f);
      if (!calm && tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= s;
      req_ch.first  <= f;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_sample(s, f);
   endtask

   // drop valid, wait for all results, then let the sequencer settle
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (!sb.drained()) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [ksm_pkg::DATA_W-1:0] pick_noise();
      case ($urandom_range(0, 5))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom;
         default: return $urandom_range(0, 32'h4000_0000) >> $urandom_range(0, 12);
      endcase
   endfunction

   task automatic send_random(bit restart);
      logic signed [ksm_pkg::DATA_W-1:0] s;
      logic                              f;
      int unsigned                       sh;
      f = restart || ($urandom_range(0, 24) == 0);
      if (f) begin
         if ($urandom_range(0, 3) == 0) level = $urandom;
         else level = int'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      end
      sh = $urandom_range(4, 20);
      // mostly noisy samples around the level, some full-range outliers
      if ($urandom_range(0, 9) == 0) s = $urandom;
      else s = level + int'($urandom_range(0, 1 << sh)) - (1 << (sh - 1));
      send_sample(s, f);
   endtask

   initial begin
      calm        = 1'b0;
      tx_idle_on  = 1'b1;
      rx_idle_on  = 1'b1;
      hold_len    = 0;
      level       = 0;
      reset       <= 1'b1;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      req_ch.valid  <= 1'b0;
      req_ch.sample <= '0;
      req_ch.first  <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // steps before any restart run on the reset state
      send_sample(32'sh0000_0000, 1'b0);
      send_sample(32'sh7FFF_FFFF, 1'b0);
      wait_idle();
      // zero denominator: P and R both zero
      csr_write(ksm_pkg::REG_MEAS_VAR, 32'h0);
      send_sample(32'sh8000_0000, 1'b0);
      wait_idle();
      csr_write(ksm_pkg::REG_MEAS_VAR, ksm_pkg::MEAS_VAR_RESET);
      send_sample(32'sh7FFF_FFFF, 1'b1);
      send_sample(32'sh8000_0000, 1'b0);
      send_sample(32'sh8000_0000, 1'b1);
      send_sample(32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sh0001_0000, 1'b1);
      send_sample(32'sh0001_8000, 1'b0);
      send_sample(32'sh0000_8000, 1'b0);
      send_sample(-32'sh0000_0001, 1'b0);
      wait_idle();
      // all-ones noise and error: covariance saturation
      csr_write(ksm_pkg::REG_PROC_VAR, 32'hFFFF_FFFF);
      csr_write(ksm_pkg::REG_MEAS_VAR, 32'hFFFF_FFFF);
      csr_write(ksm_pkg::REG_ERR_INIT, 32'hFFFF_FFFF);
      send_sample(32'sh7FFF_FFFF, 1'b1);
      send_sample(32'sh8000_0000, 1'b0);
      send_sample(32'sh1234_5678, 1'b0);
      wait_idle();
      // everything zero: restart into a zero denominator
      csr_write(ksm_pkg::REG_PROC_VAR, 32'h0);
      csr_write(ksm_pkg::REG_MEAS_VAR, 32'h0);
      csr_write(ksm_pkg::REG_ERR_INIT, 32'h0);
      send_sample(32'sh4000_0000, 1'b1);
      send_sample(-32'sh4000_0000, 1'b0);
      wait_idle();
      // write past the map is dropped
      csr_write(REG_UNMAPPED, 32'hFFFF_FFFF);
      send_sample(32'sh0002_0000, 1'b1);
      send_sample(32'sh0003_0000, 1'b0);
      wait_idle();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == PHASES - 1) begin
            calm = 1'b1;
            csr_write(ksm_pkg::REG_PROC_VAR, ksm_pkg::PROC_VAR_RESET);
            csr_write(ksm_pkg::REG_MEAS_VAR, ksm_pkg::MEAS_VAR_RESET);
            csr_write(ksm_pkg::REG_ERR_INIT, ksm_pkg::ERR_INIT_RESET);
         end else begin
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            csr_write(ksm_pkg::REG_PROC_VAR, pick_noise());
            csr_write(ksm_pkg::REG_MEAS_VAR, pick_noise());
            csr_write(ksm_pkg::REG_ERR_INIT, pick_noise());
            if ($urandom_range(0, 2) == 0) csr_write(REG_UNMAPPED, $urandom);
         end
         // hold results off long enough for the input to back up
         if (ph == 2) hold_len = 400;
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_random(i == 0 && $urandom_range(0, 7) != 0);
         wait_idle();
      end

      if (sb.errors == 0 && sb.drained())
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
